@@ hw/rtl/utf8_to_utf16_stream_decoder_defines.svh @@
// Assertion macros shared by the decoder's checker.
// No dependencies; include by bare file name.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define U2U_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define U2U_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/u2u_pkg.sv @@
// Package for the UTF-8 to UTF-16 stream decoder: word types, status codes,
// decoder state and constants. No dependencies.
package u2u_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS     = 3;
    localparam int RQ_DEPTH        = 4;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD_MAX   = 8'd244;

    localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [15:0] HI_SURR    = 16'hD800;
    localparam logic [15:0] LO_SURR    = 16'hDC00;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_INCOMPLETE = 2'd1,
        STATUS_INVALID    = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } s_item_t;

    typedef struct packed {
        logic [15:0] unit_value;
        logic        is_summary;
        status_t     status;
        logic [15:0] units_written;
        logic [15:0] bytes_left;
        logic        last_result;
    } m_item_t;

    typedef struct packed {
        logic [20:0] code_accum;
        logic [2:0]  seq_length;
        logic [2:0]  seq_count;
        logic        stopped;
        status_t     stop_status;
    } seq_state_t;

endpackage

@@ hw/rtl/utf8_to_utf16_stream_decoder.sv @@
// Channel   Direction  Payload   Handshake
// s_        in         s_item_t  s_valid / s_ready
// m_        out        m_item_t  m_valid / m_ready
// cfg_      in         16 bit    cfg_wr_en, no wait
// One byte per cycle while the sink takes one word per cycle; the result
// queue drains one word a cycle, so a byte giving a pair plus summary can
// stall the input register until the queue has drained.
// An accepted byte's first word reaches m_ through the input register, then the queue.
// Reset: synchronous, active low; clears all string state, capacity to 65535.
// Top level of the UTF-8 to UTF-16 stream decoder.
// Depends on u2u_pkg, u2u_step, u2u_rq.
module utf8_to_utf16_stream_decoder import u2u_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  s_item_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output m_item_t     m_item,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic                   in_valid_reg;
    s_item_t                in_item_reg;
    logic [15:0]            cap_reg;
    seq_state_t             seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] units_reg, units_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] consumed_reg, consumed_next;
    m_item_t                res [MAX_RESULTS];
    logic [1:0]             res_count;
    logic                   can_take;
    logic                   advance;

    assign advance = in_valid_reg && can_take;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= '0;
            units_reg    <= '0;
            total_reg    <= '0;
            consumed_reg <= '0;
        end else if (advance) begin
            seq_reg      <= seq_next;
            units_reg    <= units_next;
            total_reg    <= total_next;
            consumed_reg <= consumed_next;
        end
    end

    u2u_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item          (in_item_reg),
        .out_capacity  (cap_reg),
        .seq_cur       (seq_reg),
        .units_cur     (units_reg),
        .total_cur     (total_reg),
        .consumed_cur  (consumed_reg),
        .seq_next      (seq_next),
        .units_next    (units_next),
        .total_next    (total_next),
        .consumed_next (consumed_next),
        .res           (res),
        .res_count     (res_count)
    );

    u2u_rq u_rq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (advance ? res_count : 2'd0),
        .push_data  (res),
        .can_take   (can_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

@@ hw/rtl/u2u_step.sv @@
// Per-byte decode step: next sequence state, counters and up to three words.
// Depends on u2u_pkg.
module u2u_step import u2u_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  s_item_t                 item,
    input  logic [15:0]             out_capacity,
    input  seq_state_t              seq_cur,
    input  logic [COUNT_WIDTH-1:0]  units_cur,
    input  logic [COUNT_WIDTH-1:0]  total_cur,
    input  logic [COUNT_WIDTH-1:0]  consumed_cur,
    output seq_state_t              seq_next,
    output logic [COUNT_WIDTH-1:0]  units_next,
    output logic [COUNT_WIDTH-1:0]  total_next,
    output logic [COUNT_WIDTH-1:0]  consumed_next,
    output m_item_t                 res [MAX_RESULTS],
    output logic [1:0]              res_count
);

    localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [2:0]             inc
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + (COUNT_WIDTH+1)'(inc);
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        return (w > CMP_W'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    seq_state_t             seq;
    logic [COUNT_WIDTH-1:0] units;
    logic [COUNT_WIDTH-1:0] total;
    logic [COUNT_WIDTH-1:0] consumed;
    seq_state_t             seq_w;
    logic [COUNT_WIDTH-1:0] units_w;
    logic [COUNT_WIDTH-1:0] total_w;
    logic [COUNT_WIDTH-1:0] consumed_w;
    logic [CMP_W-1:0]       units_x;
    logic [CMP_W-1:0]       cap_x;
    logic [7:0]             b;
    logic                   do_finish;
    logic [20:0]            cp_off;
    logic [15:0]            unit0;
    logic [15:0]            unit1;
    logic [1:0]             n_units;
    logic [COUNT_WIDTH-1:0] left;
    status_t                sum_status;
    m_item_t                summary;

    assign b     = item.data_byte;
    assign seq   = item.first_byte ? '0 : seq_cur;
    assign units = item.first_byte ? '0 : units_cur;
    assign total = item.first_byte ? '0 : total_cur;
    assign consumed = item.first_byte ? '0 : consumed_cur;
    assign units_x = CMP_W'(units);
    assign cap_x   = CMP_W'(out_capacity);

    always_comb begin
        seq_w      = seq;
        units_w    = units;
        consumed_w = consumed;
        total_w    = sat_add(total, 3'd1);
        do_finish  = 1'b0;
        cp_off     = '0;
        unit0      = '0;
        unit1      = '0;
        n_units    = 2'd0;

        if (!seq.stopped) begin
            if (seq.seq_length == 3'd0) begin
                if (units_x >= cap_x) begin
                    seq_w.stopped     = 1'b1;
                    seq_w.stop_status = STATUS_FULL;
                end else if (b[7] == 1'b0) begin
                    seq_w.seq_length = 3'd1;
                    seq_w.code_accum = {13'd0, b};
                    do_finish        = 1'b1;
                end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                    seq_w.seq_length = 3'd2;
                    seq_w.seq_count  = 3'd1;
                    seq_w.code_accum = {16'd0, b[4:0]};
                end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                    seq_w.seq_length = 3'd3;
                    seq_w.seq_count  = 3'd1;
                    seq_w.code_accum = {17'd0, b[3:0]};
                end else if ((b & CONT_MASK) == CONT_CODE || b > LEAD_MAX) begin
                    seq_w.stopped     = 1'b1;
                    seq_w.stop_status = STATUS_INVALID;
                end else begin
                    seq_w.seq_length = 3'd4;
                    seq_w.seq_count  = 3'd1;
                    seq_w.code_accum = {18'd0, b[2:0]};
                end
            end else begin
                seq_w.code_accum = {seq.code_accum[14:0], b[5:0]};
                seq_w.seq_count  = seq.seq_count + 3'd1;
                if (seq_w.seq_count >= seq.seq_length) begin
                    do_finish = 1'b1;
                end
            end
        end

        if (do_finish) begin
            if (seq_w.code_accum > BMP_MAX) begin
                if (cap_x < units_x + CMP_W'(2)) begin
                    seq_w.stopped     = 1'b1;
                    seq_w.stop_status = STATUS_FULL;
                end else begin
                    cp_off           = seq_w.code_accum - SUPP_BASE;
                    unit0            = {5'd0, cp_off[20:10]} | HI_SURR;
                    unit1            = {6'd0, cp_off[9:0]} | LO_SURR;
                    n_units          = 2'd2;
                    units_w          = sat_add(units, 3'd2);
                    consumed_w       = sat_add(consumed, seq_w.seq_length);
                    seq_w.seq_length = '0;
                    seq_w.seq_count  = '0;
                    seq_w.code_accum = '0;
                end
            end else begin
                unit0            = seq_w.code_accum[15:0];
                n_units          = 2'd1;
                units_w          = sat_add(units, 3'd1);
                consumed_w       = sat_add(consumed, seq_w.seq_length);
                seq_w.seq_length = '0;
                seq_w.seq_count  = '0;
                seq_w.code_accum = '0;
            end
        end
    end

    always_comb begin
        if (!seq_w.stopped && seq_w.seq_length != 3'd0) begin
            sum_status = STATUS_INCOMPLETE;
        end else if (seq_w.stopped) begin
            sum_status = seq_w.stop_status;
        end else begin
            sum_status = STATUS_OK;
        end
        if (total_w == {COUNT_WIDTH{1'b1}}) begin
            left = {COUNT_WIDTH{1'b1}};
        end else if (total_w > consumed_w) begin
            left = total_w - consumed_w;
        end else begin
            left = '0;
        end
        summary               = '0;
        summary.is_summary    = 1'b1;
        summary.status        = sum_status;
        summary.units_written = sat16(units_w);
        summary.bytes_left    = (total_w == {COUNT_WIDTH{1'b1}}) ? 16'hFFFF : sat16(left);
    end

    always_comb begin
        res_count = n_units + {1'b0, item.last_byte};
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '0;
        end
        res[0].unit_value = unit0;
        res[1].unit_value = unit1;
        if (item.last_byte) begin
            res[n_units] = summary;
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].last_result = (2'(i) == res_count - 2'd1) && (res_count != 2'd0);
        end
    end

    // summary clears the whole string
    assign seq_next      = item.last_byte ? '0 : seq_w;
    assign units_next    = item.last_byte ? '0 : units_w;
    assign total_next    = item.last_byte ? '0 : total_w;
    assign consumed_next = item.last_byte ? '0 : consumed_w;

endmodule

@@ hw/rtl/u2u_rq.sv @@
// Result queue: takes up to three words a cycle, hands out one while m_ready is high.
// Depends on u2u_pkg.
module u2u_rq import u2u_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  m_item_t    push_data [MAX_RESULTS],
    output logic       can_take,
    output logic       m_valid,
    input  logic       m_ready,
    output m_item_t    m_item
);

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    m_item_t          mem [RQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_after_pop;
    logic             pop;

    assign m_valid         = (count_reg != '0);
    assign m_item          = mem[rd_ptr_reg];
    assign pop             = m_valid && m_ready;
    assign count_after_pop = count_reg - CNT_W'(pop);
    assign can_take        = count_after_pop <= CNT_W'(RQ_DEPTH - MAX_RESULTS);
    assign count_next      = count_after_pop + CNT_W'(push_count);
    assign wr_ptr_next     = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next     = rd_ptr_reg + PTR_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push_count) begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

endmodule

@@ hw/rtl/u2u_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on u2u_pkg and utf8_to_utf16_stream_decoder_defines.svh.
`include "utf8_to_utf16_stream_decoder_defines.svh"

module u2u_checker import u2u_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    m_valid,
    input logic    m_ready,
    input m_item_t m_item
);

    `U2U_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result word dropped or changed while stalled")
    `U2U_ASSERT_NOW(a_sum_last, aclk, aresetn, m_valid && m_item.is_summary, m_item.last_result && m_item.unit_value == 16'd0, "summary word not last or carries a unit")
    `U2U_ASSERT_NOW(a_unit_clean, aclk, aresetn, m_valid && !m_item.is_summary, m_item.status == STATUS_OK && m_item.units_written == 16'd0 && m_item.bytes_left == 16'd0, "unit word carries summary fields")
    `U2U_ASSERT_NEXT(a_after_sum, aclk, aresetn, m_valid && m_ready && !m_item.last_result, m_valid, "word of the same byte missing")

endmodule

bind utf8_to_utf16_stream_decoder u2u_checker u_checker (.*);

@@ test/utf8_to_utf16_stream_decoder_tb.sv @@
// Self-checking testbench for utf8_to_utf16_stream_decoder: directed and random UTF-8
// strings are driven byte by byte and each result word is checked against a predictor.
// Depends on u2u_pkg and the decoder RTL.
module utf8_to_utf16_stream_decoder_tb import u2u_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PERCENT  = 13;
    localparam int          STALL_CYCLES  = 60;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 40;
    localparam int          TIMEOUT_NS    = 2_000_000;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [20:0] UNIT_MAX      = 21'h00FFFF;
    localparam logic [20:0] PAIR_BASE     = 21'h010000;
    localparam logic [15:0] HIGH_TAG      = 16'hD800;
    localparam logic [15:0] LOW_TAG       = 16'hDC00;
    localparam logic [7:0]  LEAD_LIMIT    = 8'd244;

    typedef logic [7:0] octet_q_t[$];

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    s_item_t     s_item      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    m_item_t     m_item;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    s_item_t pending_bytes[$];
    m_item_t expected_words[$];
    bit      no_idle;
    bit      hold_req;
    bit      hold_done;
    int      hold_left;
    int      failures;
    int      bytes_taken;
    int      words_checked;
    int      strings_ended;
    int      random_queued;

    // decoder state as predicted
    logic [15:0] cap_model = 16'hFFFF;
    logic [20:0] acc;
    logic [2:0]  seq_len;
    logic [2:0]  seq_cnt;
    logic        halted;
    status_t     halt_code;
    logic [15:0] units_out;
    logic [15:0] bytes_seen;
    logic [15:0] bytes_used;

    utf8_to_utf16_stream_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[16] ? COUNT_MAX : s[15:0];
    endfunction

    function automatic void clear_string();
        acc        = '0;
        seq_len    = '0;
        seq_cnt    = '0;
        halted     = 1'b0;
        halt_code  = STATUS_OK;
        units_out  = '0;
        bytes_seen = '0;
        bytes_used = '0;
    endfunction

    function automatic void halt(status_t code);
        halted    = 1'b1;
        halt_code = code;
    endfunction

    function automatic void emit_unit(ref m_item_t produced[$], input logic [15:0] unit);
        m_item_t w;
        w            = '0;
        w.unit_value = unit;
        produced.push_back(w);
        units_out = sat_add(units_out, 16'd1);
    endfunction

    function automatic void close_sequence(ref m_item_t produced[$]);
        logic [20:0] cp;
        logic [15:0] room;
        cp = acc;
        if (cp > UNIT_MAX) begin
            room = (cap_model > units_out) ? cap_model - units_out : 16'd0;
            if (room < 2) begin
                halt(STATUS_FULL);
                return;
            end
            cp = cp - PAIR_BASE;
            emit_unit(produced, 16'(cp >> 10) | HIGH_TAG);
            emit_unit(produced, {6'd0, cp[9:0]} | LOW_TAG);
        end else begin
            emit_unit(produced, cp[15:0]);
        end
        bytes_used = sat_add(bytes_used, {13'd0, seq_len});
        seq_len    = '0;
        seq_cnt    = '0;
        acc        = '0;
    endfunction

    task automatic transcode_byte(s_item_t it);
        m_item_t     produced[$];
        m_item_t     summary;
        logic [7:0]  b;
        logic [15:0] left;
        b = it.data_byte;
        if (it.first_byte) clear_string();
        bytes_seen = sat_add(bytes_seen, 16'd1);
        if (!halted) begin
            if (seq_len == 0) begin
                if (units_out >= cap_model) begin
                    halt(STATUS_FULL);
                end else if (!b[7]) begin
                    seq_len = 3'd1;
                    acc     = {13'd0, b};
                    close_sequence(produced);
                end else if (b[7:5] == 3'b110) begin
                    seq_len = 3'd2;
                    seq_cnt = 3'd1;
                    acc     = {16'd0, b[4:0]};
                end else if (b[7:4] == 4'b1110) begin
                    seq_len = 3'd3;
                    seq_cnt = 3'd1;
                    acc     = {17'd0, b[3:0]};
                end else if (b[7:6] == 2'b10 || b > LEAD_LIMIT) begin
                    halt(STATUS_INVALID);
                end else begin
                    seq_len = 3'd4;
                    seq_cnt = 3'd1;
                    acc     = {18'd0, b[2:0]};
                end
            end else begin
                acc     = {acc[14:0], b[5:0]};
                seq_cnt = seq_cnt + 3'd1;
                if (seq_cnt >= seq_len) close_sequence(produced);
            end
        end
        if (it.last_byte) begin
            if (!halted && seq_len != 0) halt(STATUS_INCOMPLETE);
            if (bytes_seen == COUNT_MAX) left = COUNT_MAX;
            else left = (bytes_seen > bytes_used) ? bytes_seen - bytes_used : 16'd0;
            summary               = '0;
            summary.is_summary    = 1'b1;
            summary.status        = halted ? halt_code : STATUS_OK;
            summary.units_written = units_out;
            summary.bytes_left    = left;
            produced.push_back(summary);
            strings_ended++;
            clear_string();
        end
        if (produced.size() != 0) produced[produced.size() - 1].last_result = 1'b1;
        foreach (produced[i]) expected_words.push_back(produced[i]);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                transcode_byte(s_item);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    s_item  <= pending_bytes.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: unit %0h, summary %0b",
                           m_item.unit_value, m_item.is_summary);
                    failures++;
                end else begin
                    m_item_t want;
                    want = expected_words.pop_front();
                    check_field("unit_value", want.unit_value, m_item.unit_value);
                    check_field("is_summary", 16'(want.is_summary), 16'(m_item.is_summary));
                    check_field("status", 16'(want.status), 16'(m_item.status));
                    check_field("units_written", want.units_written, m_item.units_written);
                    check_field("bytes_left", want.bytes_left, m_item.bytes_left);
                    check_field("last_result", 16'(want.last_result), 16'(m_item.last_result));
                    words_checked++;
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || $urandom_range(0, 99) >= IDLE_PERCENT;
            end
        end
    end

    task automatic set_capacity(logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_model = value;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_octets(octet_q_t octets, bit with_first, bit with_last, bit mid_first);
        s_item_t it;
        int      restart;
        restart = (mid_first && octets.size() > 1) ? $urandom_range(1, octets.size() - 1) : -1;
        foreach (octets[i]) begin
            it.data_byte  = octets[i];
            it.first_byte = (with_first && i == 0) || i == restart;
            it.last_byte  = with_last && i == octets.size() - 1;
            pending_bytes.push_back(it);
        end
    endtask

    task automatic queue_random_string();
        octet_q_t octets;
        int       kind;
        int       len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) octets.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 5)) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: octets.push_back(8'($urandom_range(0, 127)));
                    2: octets.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                    3: octets.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    default: octets.push_back(8'hF0 + 8'($urandom_range(0, 4)));
                endcase
                repeat (len - 1)
                    octets.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                     : 8'h80 | 8'($urandom_range(0, 63)));
            end
            if (kind == 1 && octets.size() > 1) void'(octets.pop_back());
            if (kind == 2)
                octets.insert($urandom_range(0, octets.size() - 1),
                              $urandom_range(0, 1) ? 8'h80 + 8'($urandom_range(0, 63))
                                                   : 8'hF5 + 8'($urandom_range(0, 10)));
        end
        queue_octets(octets, $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0,
                     $urandom_range(0, 9) == 0);
        random_queued += octets.size();
    endtask

    initial begin
        octet_q_t    octets;
        int          phase;
        int          target;
        logic [15:0] cap;
        clear_string();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: length extremes, pair above the plane limit, bad leads, truncation
        set_capacity(16'hFFFF);
        queue_octets('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                       8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1, 1'b1, 1'b0);
        queue_octets('{8'hF4, 8'hBF, 8'hBF, 8'hBF}, 1'b1, 1'b1, 1'b0);
        queue_octets('{8'hC0, 8'hAF}, 1'b0, 1'b1, 1'b0);
        queue_octets('{8'hF5, 8'h41}, 1'b1, 1'b1, 1'b0);
        queue_octets('{8'h80}, 1'b1, 1'b1, 1'b0);
        queue_octets('{8'hE2, 8'h82}, 1'b1, 1'b1, 1'b0);
        wait_drained();
        set_capacity(16'd0);
        queue_octets('{8'h41}, 1'b1, 1'b1, 1'b0);
        wait_drained();
        set_capacity(16'd1);
        queue_octets('{8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b1, 1'b1, 1'b0);
        wait_drained();
        // capacity raised with a string still open
        set_capacity(16'd2);
        queue_octets('{8'h41, 8'h42}, 1'b1, 1'b0, 1'b0);
        wait_drained();
        set_capacity(16'd3);
        queue_octets('{8'h43, 8'h44}, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // sink held off while pairs keep arriving
        set_capacity(16'hFFFF);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (6) begin
            octets.push_back(8'hF0);
            octets.push_back(8'h9F);
            octets.push_back(8'h98);
            octets.push_back(8'h80 | 8'($urandom_range(0, 63)));
            octets.push_back(8'($urandom_range(0, 127)));
        end
        queue_octets(octets, 1'b1, 1'b1, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        phase = 0;
        while (random_queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: cap = 16'd0;
                1: cap = 16'hFFFF;
                2: cap = 16'd1;
                default: cap = 16'($urandom_range(2, 12));
            endcase
            set_capacity(cap);
            no_idle = (phase == 2);
            target  = random_queued + ((phase == 2) ? 30 : 16);
            while (random_queued < target) queue_random_string();
            wait_drained();
            phase++;
        end
        no_idle = 1'b0;

        $display("Checked %0d result words from %0d source bytes across %0d strings;",
                 words_checked, bytes_taken, strings_ended);
        $display("capacities from 0 to 65535, malformed input, sink hold-off.");
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $error("timeout: %0d bytes pending, %0d words outstanding",
               pending_bytes.size(), expected_words.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
